@@ src/clsr_pkg.sv @@
package clsr_pkg;

  // Widths
  localparam int unsigned GEN_W  = 31;
  localparam int unsigned MUL_W  = 16;
  localparam int unsigned PROD_W = GEN_W + MUL_W;

  // Default shuffle depth and the extra warm-up steps taken before the fill
  localparam int unsigned TABLE_SIZE_DEF = 32;
  localparam int unsigned WARMUP_EXTRA   = 8;

  // Generator one
  localparam logic [GEN_W-1:0] MOD_ONE  = 31'd2147483563;
  localparam logic [MUL_W-1:0] MUL_ONE  = 16'd40014;
  localparam logic [7:0]       FOLD_ONE = 8'd85;     // 2^31 mod MOD_ONE

  // Generator two
  localparam logic [GEN_W-1:0] MOD_TWO  = 31'd2147483399;
  localparam logic [MUL_W-1:0] MUL_TWO  = 16'd40692;
  localparam logic [7:0]       FOLD_TWO = 8'd249;    // 2^31 mod MOD_TWO

  // Output shaping
  localparam logic [GEN_W-1:0] WRAP_ADD = 31'd2147483562;
  localparam logic [GEN_W-1:0] DEV_MAX  = 31'd2147483305;

  // Reset and seed values
  localparam logic [GEN_W-1:0] GEN_ONE_INIT = 31'd1;
  localparam logic [GEN_W-1:0] GEN_TWO_INIT = 31'd123456789;
  localparam logic [GEN_W-1:0] SEED_FLOOR   = 31'd1;

  // Command codes
  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM_MUL,
    ST_WARM_FOLD,
    ST_MUL,
    ST_READ,
    ST_WRITE
  } state_t;

  // Reduce a 47-bit product modulo m = 2^31 - c: fold the high part down
  // once, then a single conditional subtract (the sum stays below 2m).
  function automatic logic [GEN_W-1:0] mod_fold(input logic [PROD_W-1:0] p,
                                                input logic [7:0]        c,
                                                input logic [GEN_W-1:0]  m);
    logic [23:0] hc;
    logic [31:0] s;
    logic [31:0] d;
    hc = p[PROD_W-1:GEN_W] * c;
    s  = {8'd0, hc} + {1'b0, p[GEN_W-1:0]};
    d  = s - {1'b0, m};
    return (s >= {1'b0, m}) ? d[GEN_W-1:0] : s[GEN_W-1:0];
  endfunction

endpackage

@@ src/combined_lcg_shuffle_rng_top.sv @@
// Combined two-generator uniform random source with a shuffle table.
// Input channel (in_valid/in_ready): cmd selects a plain draw or a reseed
// followed by a draw; seed_value is used only on reseed (zero acts as one).
// Output channel (out_valid/out_ready): one deviate per item, a numerator
// over 2147483563, clamped to 1..2147483305.
// A draw runs multiply, fold plus table read, then table write back, and the
// block takes no new item until it returns to idle. A reseed first runs the
// warm-up walk, each step a multiply state then a fold state of generator one.
// The shuffle table is one synchronous memory with a registered read.
// Reset puts both generators and the last output at their start values and
// clears the per-entry valid bits, so unwritten table entries read as zero.
// A finished result sits in the output register; the block accepts a new
// item while it waits, but holds in its write-back step until the register
// is free when the receiver stalls.
module combined_lcg_shuffle_rng_top #(
  parameter int unsigned TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [clsr_pkg::GEN_W-1:0]  seed_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [clsr_pkg::GEN_W-1:0]  deviate
);

  localparam int unsigned SLOT_W     = $clog2(TABLE_SIZE);
  localparam int unsigned Q_W        = SLOT_W + 1;
  localparam int unsigned WARM_STEPS = TABLE_SIZE + clsr_pkg::WARMUP_EXTRA;
  localparam int unsigned CNT_W      = $clog2(WARM_STEPS);
  localparam longint unsigned SLOT_DIV = 64'd1 + 64'(clsr_pkg::WRAP_ADD) / TABLE_SIZE;
  localparam int unsigned DIV_BITS   = $clog2(SLOT_DIV);
  localparam int unsigned SHIFT      = clsr_pkg::GEN_W + DIV_BITS;
  localparam longint unsigned RECIP  = ((64'd1 << SHIFT) + SLOT_DIV - 64'd1) / SLOT_DIV;
  localparam int unsigned RECIP_W    = 33;
  localparam int unsigned SPROD_W    = clsr_pkg::GEN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_K  = RECIP_W'(RECIP);
  localparam logic [SLOT_W-1:0]  SLOT_MAX = SLOT_W'(TABLE_SIZE - 1);
  localparam logic [Q_W-1:0]     Q_MAX    = Q_W'(TABLE_SIZE - 1);

  clsr_pkg::state_t state, state_next;

  // Generator state and last shuffled output
  logic [clsr_pkg::GEN_W-1:0]  g1, g2, last;
  logic [CNT_W-1:0]            cnt;
  logic [clsr_pkg::PROD_W-1:0] prod1, prod2;
  logic [SPROD_W-1:0]          prod_slot;
  logic [SLOT_W-1:0]           slot;

  // Shuffle table memory and its valid bits
  logic [clsr_pkg::GEN_W-1:0]  shuf_mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0]       shuf_vld;
  logic [clsr_pkg::GEN_W-1:0]  rd_data;
  logic                        rd_vld;

  // Control decodes
  logic                        out_free;
  logic                        rd_en;
  logic                        mem_we;
  logic [SLOT_W-1:0]           mem_wa;
  logic [clsr_pkg::GEN_W-1:0]  mem_wd;
  logic                        warm_wr;
  logic                        draw_wr;

  // Datapath combinational values
  logic [clsr_pkg::GEN_W-1:0]  g1_fold, g2_fold, seed_eff;
  logic [Q_W-1:0]              quot;
  logic [SLOT_W-1:0]           slot_next;
  logic [clsr_pkg::GEN_W-1:0]  tbl_val;
  logic [31:0]                 diff;
  logic [clsr_pkg::GEN_W-1:0]  v_next;
  logic [clsr_pkg::GEN_W-1:0]  deviate_next;

  assign out_free = !out_valid || out_ready;
  assign g1_fold  = clsr_pkg::mod_fold(prod1, clsr_pkg::FOLD_ONE, clsr_pkg::MOD_ONE);
  assign g2_fold  = clsr_pkg::mod_fold(prod2, clsr_pkg::FOLD_TWO, clsr_pkg::MOD_TWO);
  assign seed_eff = (seed_value == '0) ? clsr_pkg::SEED_FLOOR : seed_value;

  // Slot from reciprocal product, clamped to the last entry
  assign quot      = prod_slot[SHIFT +: Q_W];
  assign slot_next = (quot > Q_MAX) ? SLOT_MAX : quot[SLOT_W-1:0];

  // Table entry minus generator two, wrapped into 1..MOD_ONE-1
  assign tbl_val = rd_vld ? rd_data : '0;
  assign diff    = {1'b0, tbl_val} - {1'b0, g2};
  always_comb begin
    if (diff[31] || diff == '0) begin
      v_next = diff[clsr_pkg::GEN_W-1:0] + clsr_pkg::WRAP_ADD;
    end else begin
      v_next = diff[clsr_pkg::GEN_W-1:0];
    end
    deviate_next = (v_next > clsr_pkg::DEV_MAX) ? clsr_pkg::DEV_MAX : v_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      clsr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (cmd == clsr_pkg::CMD_RESEED) ? clsr_pkg::ST_WARM_MUL
                                                    : clsr_pkg::ST_MUL;
        end
      end
      clsr_pkg::ST_WARM_MUL:  state_next = clsr_pkg::ST_WARM_FOLD;
      clsr_pkg::ST_WARM_FOLD: begin
        state_next = (cnt == '0) ? clsr_pkg::ST_MUL : clsr_pkg::ST_WARM_MUL;
      end
      clsr_pkg::ST_MUL:  state_next = clsr_pkg::ST_READ;
      clsr_pkg::ST_READ: state_next = clsr_pkg::ST_WRITE;
      clsr_pkg::ST_WRITE: begin
        if (out_free) begin
          state_next = clsr_pkg::ST_IDLE;
        end
      end
      default: state_next = clsr_pkg::ST_IDLE;
    endcase
  end

  // State decodes
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    warm_wr  = 1'b0;
    draw_wr  = 1'b0;
    case (state)
      clsr_pkg::ST_IDLE:      in_ready = 1'b1;
      clsr_pkg::ST_WARM_FOLD: warm_wr  = (cnt < CNT_W'(TABLE_SIZE));
      clsr_pkg::ST_READ:      rd_en    = 1'b1;
      clsr_pkg::ST_WRITE:     draw_wr  = out_free;
      default: ;
    endcase
  end

  // Memory write port mux
  assign mem_we = warm_wr || draw_wr;
  assign mem_wa = warm_wr ? cnt[SLOT_W-1:0] : slot;
  assign mem_wd = warm_wr ? g1_fold : g1;

  // Shuffle table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      shuf_mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data <= shuf_mem[slot_next];
      rd_vld  <= shuf_vld[slot_next];
    end
  end

  // Valid bits: reset makes every entry read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      shuf_vld <= '0;
    end else if (mem_we) begin
      shuf_vld[mem_wa] <= 1'b1;
    end
  end

  // Multiplier and slot registers
  always_ff @(posedge clk) begin
    prod1     <= g1 * clsr_pkg::MUL_ONE;
    prod2     <= g2 * clsr_pkg::MUL_TWO;
    prod_slot <= last * RECIP_K;
    if (rd_en) begin
      slot <= slot_next;
    end
    if (state == clsr_pkg::ST_IDLE) begin
      cnt <= CNT_W'(WARM_STEPS - 1);
    end else if (state == clsr_pkg::ST_WARM_FOLD) begin
      cnt <= cnt - CNT_W'(1);
    end
    if (draw_wr) begin
      deviate <= deviate_next;
    end
  end

  // Control and generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= clsr_pkg::ST_IDLE;
      out_valid <= 1'b0;
      g1        <= clsr_pkg::GEN_ONE_INIT;
      g2        <= clsr_pkg::GEN_TWO_INIT;
      last      <= '0;
    end else begin
      state <= state_next;
      if (draw_wr) begin
        out_valid <= 1'b1;
        last      <= v_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_valid && in_ready && cmd == clsr_pkg::CMD_RESEED) begin
        g1 <= seed_eff;
        g2 <= seed_eff;
      end
      if (state == clsr_pkg::ST_WARM_FOLD) begin
        g1 <= g1_fold;
        if (cnt == '0) begin
          last <= g1_fold;
        end
      end
      if (state == clsr_pkg::ST_READ) begin
        g1 <= g1_fold;
        g2 <= g2_fold;
      end
    end
  end

  // Results stay inside the clamp range
  a_dev_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (deviate != '0) && (deviate <= clsr_pkg::DEV_MAX))
    else $error("deviate out of range");

  // Folded generators are fully reduced
  a_gen_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == clsr_pkg::ST_READ) |=> (g1 < clsr_pkg::MOD_ONE) && (g2 < clsr_pkg::MOD_TWO))
    else $error("generator not reduced");

  // Reseed starts the full warm-up walk
  a_reseed_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && cmd == clsr_pkg::CMD_RESEED) |=>
      (state == clsr_pkg::ST_WARM_MUL) && (cnt == CNT_W'(WARM_STEPS - 1)))
    else $error("reseed did not start warm-up");

  // Last warm-up step leaves slot zero as the last output
  a_warm_last: assert property (@(posedge clk) disable iff (rst)
    (state == clsr_pkg::ST_WARM_FOLD && cnt == '0) |=> (last == g1))
    else $error("last output not loaded from slot zero");

  // Write-back always produces a result item
  a_write_out: assert property (@(posedge clk) disable iff (rst)
    (state == clsr_pkg::ST_WRITE && out_free) |=>
      out_valid && (state == clsr_pkg::ST_IDLE))
    else $error("write-back lost its result");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int unsigned GEN_W         = clsr_pkg::GEN_W;
  localparam int unsigned DEPTH         = clsr_pkg::TABLE_SIZE_DEF;
  localparam longint      Q_ONE         = 53668;
  localparam longint      R_ONE         = 12211;
  localparam longint      Q_TWO         = 52774;
  localparam longint      R_TWO         = 3791;
  localparam longint      SLOT_SPAN     = 1 + longint'(clsr_pkg::WRAP_ADD) / DEPTH;
  localparam int          DIRECTED_ROWS = 19;
  localparam int          RANDOM_ITEMS  = 1530;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          IDLE_LIMIT    = 3000;
  localparam int          DRAIN_CYCLES  = 20;

  typedef struct {
    logic             cmd;
    logic [GEN_W-1:0] seed;
    bit               known;
    logic [GEN_W-1:0] dev;
  } stim_row_t;

  logic             clk;
  logic             rst        = 1'b1;
  logic             in_valid   = 1'b0;
  logic             in_ready;
  logic             cmd        = clsr_pkg::CMD_DRAW;
  logic [GEN_W-1:0] seed_value = '0;
  logic             out_valid;
  logic             out_ready  = 1'b0;
  logic [GEN_W-1:0] deviate;

  // Predictor state: both generators, last mixed output, shuffle table
  longint lcg_one;
  longint lcg_two;
  longint mix_last;
  longint mix_table [DEPTH];

  logic [GEN_W-1:0] deviate_q [$];
  stim_row_t        stim_rows [DIRECTED_ROWS];
  int               mismatch_count = 0;
  int               burst_left     = 0;
  int               idle_cycles    = 0;
  logic             hold_req       = 1'b0;
  logic             hold_seen      = 1'b0;
  int               hold_left      = 0;
  int               stall_mode     = 0;
  int               mode_timer     = 0;

  combined_lcg_shuffle_rng_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .seed_value (seed_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .deviate    (deviate)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // One multiplicative step, x * a mod m, split so nothing overflows
  function automatic longint lcg_step(input longint x, input longint a, input longint m,
                                      input longint q, input longint r);
    longint k;
    longint v;
    k = x / q;
    v = a * (x - k * q) - k * r;
    if (v < 0) v += m;
    return v;
  endfunction

  // Advance the predictor by one item and return the deviate it yields
  function automatic logic [GEN_W-1:0] draw_deviate(input logic c, input logic [GEN_W-1:0] s);
    longint seed;
    longint slot;
    longint v;
    if (c == clsr_pkg::CMD_RESEED) begin
      seed = longint'(s);
      if (seed < 1) seed = 1;
      lcg_one = seed;
      lcg_two = seed;
      // warm-up walk; the last DEPTH steps fill the table from the top down
      for (int i = DEPTH + clsr_pkg::WARMUP_EXTRA - 1; i >= 0; i--) begin
        lcg_one = lcg_step(lcg_one, longint'(clsr_pkg::MUL_ONE), longint'(clsr_pkg::MOD_ONE),
                           Q_ONE, R_ONE);
        if (i < DEPTH) mix_table[i] = lcg_one;
      end
      mix_last = mix_table[0];
    end
    lcg_one = lcg_step(lcg_one, longint'(clsr_pkg::MUL_ONE), longint'(clsr_pkg::MOD_ONE),
                       Q_ONE, R_ONE);
    lcg_two = lcg_step(lcg_two, longint'(clsr_pkg::MUL_TWO), longint'(clsr_pkg::MOD_TWO),
                       Q_TWO, R_TWO);
    slot = mix_last / SLOT_SPAN;
    if (slot < 0) slot = 0;
    if (slot >= DEPTH) slot = DEPTH - 1;
    v = mix_table[slot] - lcg_two;
    mix_table[slot] = lcg_one;
    if (v < 1) v += longint'(clsr_pkg::WRAP_ADD);
    mix_last = v;
    if (v > longint'(clsr_pkg::DEV_MAX)) v = longint'(clsr_pkg::DEV_MAX);
    return v[GEN_W-1:0];
  endfunction

  // Offer one item in bursts with random gaps; predict once it is taken
  task automatic offer(input logic c, input logic [GEN_W-1:0] s, input bit known,
                       input logic [GEN_W-1:0] dev);
    int               gap;
    logic [GEN_W-1:0] want;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid   <= 1'b1;
    cmd        <= c;
    seed_value <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = draw_deviate(c, s);
    if (known) want = dev;
    deviate_q.push_back(want);
  endtask

  // Receiver: stall pattern is redrawn each time its mode timer wraps, plus one long hold
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (mode_timer == 255) begin
        stall_mode <= $urandom_range(0, 3);
        mode_timer <= 0;
      end else begin
        mode_timer <= mode_timer + 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk) begin
    logic [GEN_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (deviate_q.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        $display("%0t: deviate mismatch, expected none, actual %0d", $time, deviate);
      end else begin
        want = deviate_q.pop_front();
        if (deviate !== want) begin
          mismatch_count <= mismatch_count + 1;
          $display("%0t: deviate mismatch, expected %0d, actual %0d", $time, want, deviate);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic             c;
    logic [GEN_W-1:0] s;

    // predictor starts from the reset state
    lcg_one  = longint'(clsr_pkg::GEN_ONE_INIT);
    lcg_two  = longint'(clsr_pkg::GEN_TWO_INIT);
    mix_last = 0;
    foreach (mix_table[i]) mix_table[i] = 0;

    // directed items: draws before any seed, seed extremes, zero seed
    stim_rows[0]  = '{clsr_pkg::CMD_DRAW,   31'd0,          1'b1, 31'd1407495835};
    stim_rows[1]  = '{clsr_pkg::CMD_DRAW,   31'd0,          1'b0, 31'd0};
    stim_rows[2]  = '{clsr_pkg::CMD_DRAW,   31'h7FFFFFFF,   1'b0, 31'd0};
    stim_rows[3]  = '{clsr_pkg::CMD_RESEED, 31'd0,          1'b0, 31'd0};
    stim_rows[4]  = '{clsr_pkg::CMD_DRAW,   31'd0,          1'b0, 31'd0};
    stim_rows[5]  = '{clsr_pkg::CMD_RESEED, 31'd1,          1'b0, 31'd0};
    stim_rows[6]  = '{clsr_pkg::CMD_DRAW,   31'd0,          1'b0, 31'd0};
    stim_rows[7]  = '{clsr_pkg::CMD_RESEED, 31'h7FFFFFFF,   1'b0, 31'd0};
    stim_rows[8]  = '{clsr_pkg::CMD_DRAW,   31'd0,          1'b0, 31'd0};
    stim_rows[9]  = '{clsr_pkg::CMD_RESEED, clsr_pkg::MOD_ONE, 1'b0, 31'd0};
    stim_rows[10] = '{clsr_pkg::CMD_RESEED, clsr_pkg::MOD_ONE - 31'd1, 1'b0, 31'd0};
    stim_rows[11] = '{clsr_pkg::CMD_RESEED, clsr_pkg::MOD_TWO, 1'b0, 31'd0};
    stim_rows[12] = '{clsr_pkg::CMD_DRAW,   31'd0,          1'b0, 31'd0};
    stim_rows[13] = '{clsr_pkg::CMD_RESEED, 31'h55555555,   1'b0, 31'd0};
    stim_rows[14] = '{clsr_pkg::CMD_DRAW,   31'h7FFFFFFF,   1'b0, 31'd0};
    stim_rows[15] = '{clsr_pkg::CMD_RESEED, 31'h2AAAAAAA,   1'b0, 31'd0};
    stim_rows[16] = '{clsr_pkg::CMD_RESEED, clsr_pkg::GEN_TWO_INIT, 1'b0, 31'd0};
    stim_rows[17] = '{clsr_pkg::CMD_DRAW,   31'd0,          1'b0, 31'd0};
    stim_rows[18] = '{clsr_pkg::CMD_DRAW,   31'd0,          1'b0, 31'd0};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i])
      offer(stim_rows[i].cmd, stim_rows[i].seed, stim_rows[i].known, stim_rows[i].dev);

    // random items: mostly draws, an occasional reseed
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      c = ($urandom_range(0, 19) == 0) ? clsr_pkg::CMD_RESEED : clsr_pkg::CMD_DRAW;
      case ($urandom_range(0, 7))
        0: s = GEN_W'($urandom_range(0, 3));
        1: s = clsr_pkg::MOD_TWO - 31'd2 + GEN_W'($urandom_range(0, 254));
        default: s = GEN_W'($urandom);
      endcase
      // stall the receiver for a long stretch while items keep coming
      if (n == 500) hold_req <= 1'b1;
      offer(c, s, 1'b0, 31'd0);
    end
    in_valid <= 1'b0;

    while (deviate_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && deviate_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ combined_lcg_shuffle_rng_top.f @@
src/clsr_pkg.sv
src/combined_lcg_shuffle_rng_top.sv
tb/sv/tb.sv
